>>> src/vfcm_pkg.sv
// Shared types, constants and coefficient builders for the false color mapper.
// Used by the coefficient stage, the color arithmetic stages and the top level.
`default_nettype none
package vfcm_pkg;

  localparam int COLOR_BITS = 8;
  localparam int CMAX = 255;
  localparam int PAL_COUNT = 21;
  localparam int COEF_BITS = 16;
  localparam int QW = 17;
  localparam int RW = 13;
  localparam int RECIP_SHIFT = 16;
  localparam logic [RECIP_SHIFT-1:0] RECIP3 = 16'd21846;
  localparam logic [RECIP_SHIFT-1:0] RECIP7 = 16'd9363;

  localparam logic [1:0] REG_LOW = 2'd0;
  localparam logic [1:0] REG_HIGH = 2'd1;
  localparam logic [1:0] REG_PAL = 2'd2;

  // Stop colors of the blended palettes: [table][stop][channel].
  localparam int STOP [4][3][3] = '{
    '{'{200, 60, 0}, '{250, 160, 110}, '{250, 160, 110}},
    '{'{55, 55, 45}, '{200, 60, 0}, '{250, 160, 110}},
    '{'{0, 255, 0}, '{255, 150, 0}, '{255, 250, 240}},
    '{'{0, 160, 0}, '{180, 220, 0}, '{250, 220, 170}}
  };

  typedef enum logic [1:0] {
    DIV1 = 2'd0,
    DIV2 = 2'd1,
    DIV3 = 2'd2,
    DIV7 = 2'd3
  } div_e_t;

  // A component is floor((a*t + b*ONE) / (2*c*ONE)), then saturated.
  typedef struct packed {
    logic signed [COEF_BITS-1:0] a;
    logic signed [COEF_BITS-1:0] b;
    div_e_t                      c;
  } coef_t;

  function automatic div_e_t div_code(input int d);
    div_e_t r;
    unique case (d)
      2: r = DIV2;
      3: r = DIV3;
      7: r = DIV7;
      default: r = DIV1;
    endcase
    return r;
  endfunction

  function automatic coef_t c_const(input int v);
    coef_t r;
    r.a = '0;
    r.b = COEF_BITS'(2 * v + 1);
    r.c = DIV1;
    return r;
  endfunction

  function automatic coef_t c_ramp(input int k, input int m);
    coef_t r;
    r.a = COEF_BITS'(2 * CMAX * k);
    r.b = COEF_BITS'(2 * CMAX * m + 1);
    r.c = DIV1;
    return r;
  endfunction

  function automatic coef_t c_mix(input int ca, input int cb);
    coef_t r;
    r.a = COEF_BITS'(2 * (cb - ca));
    r.b = COEF_BITS'(2 * ca + 1);
    r.c = DIV1;
    return r;
  endfunction

  function automatic coef_t c_lo(input int ca, input int cb, input int sn, input int sd);
    coef_t r;
    r.a = COEF_BITS'(2 * (cb - ca) * sd);
    r.b = COEF_BITS'((2 * ca + 1) * sn);
    r.c = div_code(sn);
    return r;
  endfunction

  function automatic coef_t c_hi(input int ca, input int cb, input int sn, input int sd);
    coef_t r;
    r.a = COEF_BITS'(2 * (cb - ca) * sd);
    r.b = COEF_BITS'((2 * ca + 1) * (sd - sn) - 2 * (cb - ca) * sn);
    r.c = div_code(sd - sn);
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/vfcm_div_stage.sv
// One restoring division step: produces one quotient bit per stage.
// No package dependency; instantiated once per quotient bit by the top level.
`default_nettype none
module vfcm_div_stage #(
  parameter int SW = 16,
  parameter int FB = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire logic          vld_i,
  input  wire logic [SW:0]   r_i,
  input  wire logic [FB:0]   q_i,
  input  wire logic [SW-1:0] den,
  output logic               vld_o,
  output logic [SW:0]        r_o,
  output logic [FB:0]        q_o
);

  logic          vld_r;
  logic [SW:0]   r_r, r_nxt;
  logic [FB:0]   q_r, q_nxt;
  logic          ge;
  logic [SW:0]   d;

  always_comb begin
    ge = r_i >= {1'b0, den};
    d = ge ? (r_i - {1'b0, den}) : r_i;
    r_nxt = {d[SW-1:0], 1'b0};
    q_nxt = {q_i[FB-1:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r_r <= r_nxt;
      q_r <= q_nxt;
    end
  end

  assign vld_o = vld_r;
  assign r_o = r_r;
  assign q_o = q_r;

endmodule
`default_nettype wire

>>> src/vfcm_coef.sv
// Palette stage: finds the segment of the fraction and picks per-channel coefficients.
// Depends on vfcm_pkg for the coefficient type, stop colors and builders.
`default_nettype none
module vfcm_coef
  import vfcm_pkg::*;
#(
  parameter int FB = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        vld_i,
  input  wire logic [FB:0] q_i,
  input  wire logic        zero,
  input  wire logic [4:0]  pal,
  output logic             vld_o,
  output logic [FB:0]      t_o,
  output coef_t            coef_o [3]
);

  logic        vld_r;
  logic [FB:0] t_r, t_nxt;
  coef_t       cf_r [3];
  coef_t       cf_nxt [3];

  logic [FB+3:0] tx, t2, t3, t4, t5, t6, t10;
  logic [2:0]    s2, s3, s4, s5, s6;
  logic          lo5, lo10;
  logic [FB+3:0] one2, one3;

  function automatic logic [2:0] cap(input logic [2:0] s, input logic [2:0] n);
    return (s >= n) ? (n - 3'd1) : s;
  endfunction

  always_comb begin
    t_nxt = zero ? '0 : q_i;
    tx = {3'b000, t_nxt};
    t2 = tx * 4'd2;
    t3 = tx * 4'd3;
    t4 = tx * 4'd4;
    t5 = tx * 4'd5;
    t6 = tx * 4'd6;
    t10 = tx * 4'd10;
    s2 = cap(t2[FB+2:FB], 3'd2);
    s3 = cap(t3[FB+2:FB], 3'd3);
    s4 = cap(t4[FB+2:FB], 3'd4);
    s5 = cap(t5[FB+2:FB], 3'd5);
    s6 = cap(t6[FB+2:FB], 3'd6);
    one2 = (FB+4)'(2) << FB;
    one3 = (FB+4)'(3) << FB;
    lo5 = t5 < one2;
    lo10 = t10 < one3;

    cf_nxt[0] = c_const(CMAX);
    cf_nxt[1] = c_const(CMAX);
    cf_nxt[2] = c_const(CMAX);

    unique case (pal)
      5'd1: begin
        unique case (s4)
          3'd0: begin
            cf_nxt[0] = c_const(0); cf_nxt[1] = c_ramp(4, 0); cf_nxt[2] = c_const(CMAX);
          end
          3'd1: begin
            cf_nxt[0] = c_const(0); cf_nxt[1] = c_const(CMAX); cf_nxt[2] = c_ramp(-4, 2);
          end
          3'd2: begin
            cf_nxt[0] = c_ramp(4, -2); cf_nxt[1] = c_const(CMAX); cf_nxt[2] = c_const(0);
          end
          default: begin
            cf_nxt[0] = c_const(CMAX); cf_nxt[1] = c_ramp(-4, 4); cf_nxt[2] = c_const(0);
          end
        endcase
      end
      5'd2: begin
        cf_nxt[0] = c_ramp(1, 0); cf_nxt[1] = c_const(0); cf_nxt[2] = c_ramp(-1, 1);
      end
      5'd3: begin
        cf_nxt[0] = c_ramp(1, 0); cf_nxt[1] = c_ramp(1, 0); cf_nxt[2] = c_ramp(1, 0);
      end
      5'd4: begin
        unique case (s6)
          3'd0: begin
            cf_nxt[0] = c_const(CMAX); cf_nxt[1] = c_ramp(6, 0); cf_nxt[2] = c_const(0);
          end
          3'd1: begin
            cf_nxt[0] = c_ramp(-6, 2); cf_nxt[1] = c_const(CMAX); cf_nxt[2] = c_const(0);
          end
          3'd2: begin
            cf_nxt[0] = c_const(0); cf_nxt[1] = c_const(CMAX); cf_nxt[2] = c_ramp(6, -2);
          end
          3'd3: begin
            cf_nxt[0] = c_const(0); cf_nxt[1] = c_ramp(-6, 4); cf_nxt[2] = c_const(CMAX);
          end
          3'd4: begin
            cf_nxt[0] = c_ramp(6, -4); cf_nxt[1] = c_const(0); cf_nxt[2] = c_const(CMAX);
          end
          default: begin
            cf_nxt[0] = c_const(CMAX); cf_nxt[1] = c_const(0); cf_nxt[2] = c_ramp(-6, 6);
          end
        endcase
      end
      5'd5: begin
        cf_nxt[0] = c_ramp(1, 0); cf_nxt[1] = c_const(CMAX); cf_nxt[2] = c_const(0);
      end
      5'd6: begin
        cf_nxt[0] = c_ramp(1, 0); cf_nxt[1] = c_ramp(-1, 1); cf_nxt[2] = c_ramp(1, 0);
      end
      5'd7: begin
        unique case (s4)
          3'd0: begin
            cf_nxt[0] = c_const(0); cf_nxt[1] = c_ramp(4, 0); cf_nxt[2] = c_ramp(-4, 1);
          end
          3'd1: begin
            cf_nxt[0] = c_ramp(4, -1); cf_nxt[1] = c_ramp(-4, 2); cf_nxt[2] = c_const(0);
          end
          3'd2: begin
            cf_nxt[0] = c_ramp(-4, 3); cf_nxt[1] = c_ramp(4, -2); cf_nxt[2] = c_const(0);
          end
          default: begin
            cf_nxt[0] = c_const(0); cf_nxt[1] = c_ramp(-4, 4); cf_nxt[2] = c_ramp(4, -3);
          end
        endcase
      end
      5'd8: begin
        if (s2 == 3'd0) begin
          cf_nxt[0] = c_ramp(2, 0); cf_nxt[1] = c_ramp(2, 0); cf_nxt[2] = c_ramp(2, 0);
        end else begin
          cf_nxt[0] = c_ramp(-2, 2); cf_nxt[1] = c_ramp(-2, 2); cf_nxt[2] = c_ramp(-2, 2);
        end
      end
      5'd9: begin
        unique case (s3)
          3'd0: begin
            cf_nxt[0] = c_ramp(-3, 1); cf_nxt[1] = c_const(0); cf_nxt[2] = c_ramp(3, 0);
          end
          3'd1: begin
            cf_nxt[0] = c_const(0); cf_nxt[1] = c_ramp(3, -1); cf_nxt[2] = c_const(CMAX);
          end
          default: begin
            cf_nxt[0] = c_ramp(3, -2); cf_nxt[1] = c_ramp(-3, 3); cf_nxt[2] = c_const(CMAX);
          end
        endcase
      end
      5'd10: begin
        unique case (s5)
          3'd0: begin
            cf_nxt[0] = c_const(0); cf_nxt[1] = c_ramp(5, 0); cf_nxt[2] = c_const(CMAX);
          end
          3'd1: begin
            cf_nxt[0] = c_const(0); cf_nxt[1] = c_const(CMAX); cf_nxt[2] = c_ramp(-5, 2);
          end
          3'd2: begin
            cf_nxt[0] = c_ramp(5, -2); cf_nxt[1] = c_const(CMAX); cf_nxt[2] = c_const(0);
          end
          3'd3: begin
            cf_nxt[0] = c_const(CMAX); cf_nxt[1] = c_ramp(-5, 4); cf_nxt[2] = c_const(0);
          end
          default: begin
            cf_nxt[0] = c_const(CMAX); cf_nxt[1] = c_ramp(5, -4); cf_nxt[2] = c_ramp(5, -4);
          end
        endcase
      end
      5'd11: begin
        for (int ch = 0; ch < 3; ch++) begin
          cf_nxt[ch] = c_mix(STOP[0][0][ch], STOP[0][1][ch]);
        end
      end
      5'd12: begin
        for (int ch = 0; ch < 3; ch++) begin
          cf_nxt[ch] = lo5 ? c_lo(STOP[1][0][ch], STOP[1][1][ch], 2, 5)
                           : c_hi(STOP[1][1][ch], STOP[1][2][ch], 2, 5);
        end
      end
      5'd13: begin
        for (int ch = 0; ch < 3; ch++) begin
          cf_nxt[ch] = lo10 ? c_lo(STOP[2][0][ch], STOP[2][1][ch], 3, 10)
                            : c_hi(STOP[2][1][ch], STOP[2][2][ch], 3, 10);
        end
      end
      5'd14: begin
        cf_nxt[0] = c_const(CMAX); cf_nxt[1] = c_ramp(-1, 1); cf_nxt[2] = c_const(0);
      end
      5'd15: begin
        unique case (s4)
          3'd0: begin
            cf_nxt[0] = c_const(0); cf_nxt[1] = c_ramp(4, 0); cf_nxt[2] = c_const(CMAX);
          end
          3'd1: begin
            cf_nxt[0] = c_const(0); cf_nxt[1] = c_const(CMAX); cf_nxt[2] = c_ramp(-4, 2);
          end
          3'd2: begin
            cf_nxt[0] = c_ramp(4, -2); cf_nxt[1] = c_const(CMAX); cf_nxt[2] = c_const(0);
          end
          default: begin
            cf_nxt[0] = c_const(CMAX); cf_nxt[1] = c_const(CMAX); cf_nxt[2] = c_ramp(4, -3);
          end
        endcase
      end
      5'd16: begin
        if (s2 == 3'd0) begin
          cf_nxt[0] = c_const(0); cf_nxt[1] = c_ramp(2, 0); cf_nxt[2] = c_ramp(-2, 1);
        end else begin
          cf_nxt[0] = c_ramp(2, -1); cf_nxt[1] = c_ramp(-2, 2); cf_nxt[2] = c_const(0);
        end
      end
      5'd17: begin
        if (s2 == 3'd0) begin
          cf_nxt[0] = c_const(CMAX); cf_nxt[1] = c_ramp(-2, 1); cf_nxt[2] = c_ramp(2, 0);
        end else begin
          cf_nxt[0] = c_ramp(-2, 2); cf_nxt[1] = c_ramp(2, -1); cf_nxt[2] = c_const(CMAX);
        end
      end
      5'd18: begin
        cf_nxt[0] = c_const(0); cf_nxt[1] = c_ramp(1, 0); cf_nxt[2] = c_const(CMAX);
      end
      5'd19: begin
        cf_nxt[0] = c_ramp(1, 0); cf_nxt[1] = c_ramp(1, 0); cf_nxt[2] = c_const(CMAX);
      end
      5'd20: begin
        for (int ch = 0; ch < 3; ch++) begin
          cf_nxt[ch] = lo10 ? c_lo(STOP[3][0][ch], STOP[3][1][ch], 3, 10)
                            : c_hi(STOP[3][1][ch], STOP[3][2][ch], 3, 10);
        end
      end
      default: begin
        // Palette zero is plain white.
        cf_nxt[0] = c_const(CMAX); cf_nxt[1] = c_const(CMAX); cf_nxt[2] = c_const(CMAX);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r <= t_nxt;
      cf_r <= cf_nxt;
    end
  end

  assign vld_o = vld_r;
  assign t_o = t_r;
  assign coef_o = cf_r;

endmodule
`default_nettype wire

>>> src/vfcm_color.sv
// Color arithmetic: multiply, scale and round, then divide by the segment span and saturate.
// Depends on vfcm_pkg for the coefficient type and reciprocal constants.
`default_nettype none
module vfcm_color
  import vfcm_pkg::*;
#(
  parameter int FB = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic [2:0]            en,
  input  wire logic                  vld_i,
  input  wire logic [FB:0]           t_i,
  input  coef_t                      coef_i [3],
  output logic [2:0]                 vld_o,
  output logic [COLOR_BITS-1:0]      rgb_o [3]
);

  localparam int NW = FB + COEF_BITS + 2;

  logic [2:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) vld_r[0] <= vld_i;
      if (en[1]) vld_r[1] <= vld_r[0];
      if (en[2]) vld_r[2] <= vld_r[1];
    end
  end

  assign vld_o = vld_r;

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic signed [NW-1:0]        prod_r, prod_nxt;
    logic signed [COEF_BITS-1:0] b_r;
    div_e_t                      c2_r, c3_r;
    logic signed [QW-1:0]        q1_r, q1_nxt;
    logic signed [NW-1:0]        nsum;
    logic [COLOR_BITS-1:0]       col_r, col_nxt;
    logic signed [QW-1:0]        qv;
    logic [RW-1:0]               w;
    logic [RW+RECIP_SHIFT-1:0]   wk;

    always_comb begin
      prod_nxt = NW'(coef_i[ch].a) * NW'($signed({1'b0, t_i}));
      nsum = prod_r + (NW'(b_r) <<< FB);
      q1_nxt = QW'(nsum >>> (FB + 1));
    end

    // Spans of three and seven use a reciprocal multiply; the blend values
    // there are non-negative and small, so the estimate is exact.
    always_comb begin
      w = q1_r[QW-1] ? '0 : q1_r[RW-1:0];
      wk = '0;
      unique case (c3_r)
        DIV1: qv = q1_r;
        DIV2: qv = q1_r >>> 1;
        DIV3: begin
          wk = w * RECIP3;
          qv = QW'({1'b0, wk[RW+RECIP_SHIFT-1:RECIP_SHIFT]});
        end
        DIV7: begin
          wk = w * RECIP7;
          qv = QW'({1'b0, wk[RW+RECIP_SHIFT-1:RECIP_SHIFT]});
        end
        default: qv = q1_r;
      endcase
      if (qv < 0) begin
        col_nxt = '0;
      end else if (qv > QW'(CMAX)) begin
        col_nxt = COLOR_BITS'(CMAX);
      end else begin
        col_nxt = qv[COLOR_BITS-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en[0]) begin
        prod_r <= prod_nxt;
        b_r <= coef_i[ch].b;
        c2_r <= coef_i[ch].c;
      end
      if (en[1]) begin
        q1_r <= q1_nxt;
        c3_r <= c2_r;
      end
      if (en[2]) begin
        col_r <= col_nxt;
      end
    end

    assign rgb_o[ch] = col_r;
  end

endmodule
`default_nettype wire

>>> src/value_to_false_color_map.sv
// False color mapper top level: window clamp, pipelined divider, palette and color stages.
// One request is taken every cycle while in_stall is low.
// The fraction divider sets the depth: one restoring step per quotient bit,
// FRACTION_BITS + 1 steps in all, plus the clamp, palette and three color stages.
// A stalled output holds; earlier stages keep filling bubbles until full.
// Synchronous reset clears all valid bits and restores the register defaults.
`default_nettype none
module value_to_false_color_map
  import vfcm_pkg::*;
#(
  parameter int SAMPLE_BITS = 16,
  parameter int FRACTION_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [SAMPLE_BITS-1:0] in_sample,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [COLOR_BITS-1:0]       out_red,
  output logic [COLOR_BITS-1:0]       out_green,
  output logic [COLOR_BITS-1:0]       out_blue,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [SAMPLE_BITS-1:0] cfg_data
);

  localparam int SW = SAMPLE_BITS;
  localparam int FB = FRACTION_BITS;
  localparam int NS = FB + 6;

  logic [SW-1:0] low_r, high_r;
  logic [4:0]    pal_r;
  logic [4:0]    pal_eff;
  logic [SW-1:0] den;
  logic          zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r <= '0;
      high_r <= SW'(65535);
      pal_r <= 5'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LOW:  low_r <= cfg_data;
        REG_HIGH: high_r <= cfg_data;
        REG_PAL:  pal_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    pal_eff = (pal_r >= 5'(PAL_COUNT)) ? (pal_r - 5'(PAL_COUNT)) : pal_r;
    den = high_r - low_r;
    zero = high_r <= low_r;
  end

  logic [NS-1:0] sv;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !sv[NS-1] || !out_stall;
    for (int i = NS - 2; i >= 0; i--) begin
      en[i] = !sv[i] || en[i+1];
    end
  end

  assign in_stall = !en[0];

  // Input stage: clamp into the window.
  logic          v0_r;
  logic [SW:0]   r0_r, r0_nxt;
  logic [SW-1:0] vc;

  always_comb begin
    if (in_sample < low_r) begin
      vc = low_r;
    end else if (in_sample > high_r) begin
      vc = high_r;
    end else begin
      vc = in_sample;
    end
    r0_nxt = {1'b0, vc - low_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en[0]) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      r0_r <= r0_nxt;
    end
  end

  assign sv[0] = v0_r;

  logic          dv [FB+2];
  logic [SW:0]   dr [FB+2];
  logic [FB:0]   dq [FB+2];

  assign dv[0] = v0_r;
  assign dr[0] = r0_r;
  assign dq[0] = '0;

  for (genvar k = 0; k <= FB; k++) begin : g_div
    vfcm_div_stage #(
      .SW(SW),
      .FB(FB)
    ) u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en[k+1]),
      .vld_i (dv[k]),
      .r_i   (dr[k]),
      .q_i   (dq[k]),
      .den   (den),
      .vld_o (dv[k+1]),
      .r_o   (dr[k+1]),
      .q_o   (dq[k+1])
    );
    assign sv[k+1] = dv[k+1];
  end

  logic        cv;
  logic [FB:0] ct;
  coef_t       cf [3];

  vfcm_coef #(
    .FB(FB)
  ) u_coef (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en[FB+2]),
    .vld_i  (dv[FB+1]),
    .q_i    (dq[FB+1]),
    .zero   (zero),
    .pal    (pal_eff),
    .vld_o  (cv),
    .t_o    (ct),
    .coef_o (cf)
  );

  assign sv[FB+2] = cv;

  logic [2:0]            colv;
  logic [COLOR_BITS-1:0] rgb [3];

  vfcm_color #(
    .FB(FB)
  ) u_color (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en[FB+5:FB+3]),
    .vld_i  (cv),
    .t_i    (ct),
    .coef_i (cf),
    .vld_o  (colv),
    .rgb_o  (rgb)
  );

  assign sv[FB+5:FB+3] = colv;

  assign out_valid = sv[NS-1];
  assign out_red = rgb[0];
  assign out_green = rgb[1];
  assign out_blue = rgb[2];

endmodule
`default_nettype wire
